[hdl/string_literal_unescaper_unit_defines.svh]
// Assertion macros for the string literal unescaper
`ifndef STRING_LITERAL_UNESCAPER_UNIT_DEFINES_SVH
`define STRING_LITERAL_UNESCAPER_UNIT_DEFINES_SVH

`ifndef SYNTH
`define SLU_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("slu assertion failed");
`define SLU_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("slu assertion failed");
`else
`define SLU_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define SLU_ASSERT_NXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[hdl/slu_pkg.sv]
// Types, character codes and helpers for the string literal unescaper
package slu_pkg;

    localparam logic [7:0] CH_NUL       = 8'h00;
    localparam logic [7:0] CH_TAB       = 8'h09;
    localparam logic [7:0] CH_NL        = 8'h0A;
    localparam logic [7:0] CH_CR        = 8'h0D;
    localparam logic [7:0] CH_DQUOTE    = 8'h22;
    localparam logic [7:0] CH_APOS      = 8'h27;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_LOWER_N   = 8'h6E;
    localparam logic [7:0] CH_LOWER_R   = 8'h72;
    localparam logic [7:0] CH_LOWER_T   = 8'h74;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_UNCLOSED    = 2'd1,
        ST_UNKNOWN_ESC = 2'd2
    } t_status;

    typedef struct packed {
        logic [7:0]  data;
        logic        data_valid;
        logic        last;
        t_status     status;
        logic [15:0] decoded_length;
        logic [15:0] line_number;
    } t_result;

    typedef struct packed {
        logic [1:0] count;
        t_result    e0;
        t_result    e1;
    } t_push;

    typedef struct packed {
        logic        has_res;
        t_result     res;
        logic        esc;
        logic [15:0] wc;
    } t_plain;

    function automatic logic [15:0] sat_inc(input logic [15:0] v);
        return (v == 16'hFFFF) ? v : v + 16'd1;
    endfunction

    function automatic t_plain plain_step(input logic [7:0] b, input logic mode,
                                          input logic [15:0] wc,
                                          input logic [15:0] lc);
        t_plain     p;
        logic [7:0] closer;
        closer = mode ? CH_APOS : CH_DQUOTE;
        p = '0;
        p.wc = wc;
        p.res.line_number = lc;
        if (b == closer) begin
            p.has_res = 1'b1;
            p.res.last = 1'b1;
            p.res.status = ST_OK;
            if (mode) begin
                p.res.decoded_length = wc;
            end else begin
                p.res.data_valid = 1'b1;
                p.res.decoded_length = sat_inc(wc);
            end
            p.wc = '0;
        end else if (b == CH_NUL || b == CH_NL) begin
            p.has_res = 1'b1;
            p.res.last = 1'b1;
            p.res.status = ST_UNCLOSED;
            p.res.decoded_length = wc;
            p.wc = '0;
        end else if (b == CH_BACKSLASH) begin
            p.esc = 1'b1;
        end else begin
            p.has_res = 1'b1;
            p.res.data = b;
            p.res.data_valid = 1'b1;
            p.res.status = ST_OK;
            p.res.decoded_length = sat_inc(wc);
            p.wc = sat_inc(wc);
        end
        return p;
    endfunction

endpackage

[hdl/slu_byte_if.sv]
// Source byte channel
interface slu_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] source_byte;

    modport source (output valid, output source_byte, input ready);
    modport sink (input valid, input source_byte, output ready);
endinterface

[hdl/slu_result_if.sv]
// Decoded result channel
interface slu_result_if;
    logic        valid;
    logic        ready;
    logic [7:0]  data;
    logic        data_valid;
    logic        last;
    logic [1:0]  status;
    logic [15:0] decoded_length;
    logic [15:0] line_number;

    modport source (output valid, output data, output data_valid, output last,
                    output status, output decoded_length, output line_number,
                    input ready);
    modport sink (input valid, input data, input data_valid, input last,
                  input status, input decoded_length, input line_number,
                  output ready);
endinterface

[hdl/slu_decoder.sv]
// Input register, escape state and per-byte decode into up to two results
module slu_decoder
    import slu_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    slu_byte_if.sink   i_in,
    input  logic       i_char_mode,
    input  logic       i_room,
    output t_push      o_push
);

    logic        r_in_valid;
    logic [7:0]  r_in_byte;
    logic        r_esc;
    logic [15:0] r_wc;
    logic [15:0] r_lc;
    logic        n_esc;
    logic [15:0] n_wc;
    logic [15:0] n_lc;
    logic        advance;
    logic        known;
    logic [7:0]  d;
    logic [15:0] wc1;
    t_plain      p;
    t_push       push;

    assign advance    = r_in_valid && i_room;
    assign i_in.ready = !r_in_valid || i_room;
    assign o_push     = push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_esc      <= 1'b0;
            r_wc       <= '0;
            r_lc       <= '0;
        end else begin
            if (i_in.valid && i_in.ready) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            r_esc <= n_esc;
            r_wc  <= n_wc;
            r_lc  <= n_lc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_in_byte <= i_in.source_byte;
        end
    end

    always_comb begin
        n_esc = r_esc;
        n_wc  = r_wc;
        n_lc  = r_lc;
        push  = '0;
        known = 1'b0;
        d     = r_in_byte;
        wc1   = sat_inc(r_wc);
        p     = plain_step(r_in_byte, i_char_mode, wc1, r_lc);
        if (advance) begin
            if (!r_esc) begin
                p          = plain_step(r_in_byte, i_char_mode, r_wc, r_lc);
                n_esc      = p.esc;
                n_wc       = p.wc;
                push.count = {1'b0, p.has_res};
                push.e0    = p.res;
            end else begin
                n_esc = 1'b0;
                unique case (r_in_byte)
                    CH_DQUOTE, CH_APOS, CH_BACKSLASH: begin
                        known = 1'b1;
                        d     = r_in_byte;
                    end
                    CH_LOWER_N: begin
                        known = 1'b1;
                        d     = CH_NL;
                    end
                    CH_LOWER_T: begin
                        known = 1'b1;
                        d     = CH_TAB;
                    end
                    CH_LOWER_R: begin
                        known = 1'b1;
                        d     = CH_CR;
                    end
                    CH_ZERO: begin
                        known = 1'b1;
                        d     = CH_NUL;
                    end
                    default: begin
                        known = 1'b0;
                        d     = r_in_byte;
                    end
                endcase
                if (r_in_byte == CH_NL) begin
                    n_lc = r_lc + 16'd1;
                end else if (known) begin
                    n_wc                   = wc1;
                    push.count             = 2'd1;
                    push.e0.data           = d;
                    push.e0.data_valid     = 1'b1;
                    push.e0.status         = ST_OK;
                    push.e0.decoded_length = wc1;
                    push.e0.line_number    = r_lc;
                end else begin
                    push.e0.data           = CH_BACKSLASH;
                    push.e0.data_valid     = 1'b1;
                    push.e0.status         = ST_UNKNOWN_ESC;
                    push.e0.decoded_length = wc1;
                    push.e0.line_number    = r_lc;
                    n_esc                  = p.esc;
                    n_wc                   = p.wc;
                    push.e1                = p.res;
                    push.count             = p.has_res ? 2'd2 : 2'd1;
                end
            end
        end
    end

endmodule

[hdl/slu_result_queue.sv]
// Four-entry result queue taking up to two results and giving one per cycle while the sink is ready
module slu_result_queue
    import slu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_push         i_push,
    output logic          o_room,
    slu_result_if.source  o_out
);

    t_result               r_mem [QUEUE_DEPTH];
    logic [QUEUE_AW-1:0]   r_wr;
    logic [QUEUE_AW-1:0]   r_rd;
    logic [QUEUE_CW-1:0]   r_count;
    logic [QUEUE_AW-1:0]   wr1;
    logic                  pop;
    t_result               head;

    assign wr1    = r_wr + QUEUE_AW'(1);
    assign pop    = (r_count != '0) && o_out.ready;
    assign o_room = r_count <= QUEUE_CW'(QUEUE_DEPTH - 2);
    assign head   = r_mem[r_rd];

    assign o_out.valid          = r_count != '0;
    assign o_out.data           = head.data;
    assign o_out.data_valid     = head.data_valid;
    assign o_out.last           = head.last;
    assign o_out.status         = head.status;
    assign o_out.decoded_length = head.decoded_length;
    assign o_out.line_number    = head.line_number;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= r_wr + QUEUE_AW'(i_push.count);
            r_rd    <= r_rd + QUEUE_AW'(pop);
            r_count <= r_count + QUEUE_CW'(i_push.count) - QUEUE_CW'(pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr] <= i_push.e0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr1] <= i_push.e1;
        end
    end

endmodule

[hdl/string_literal_unescaper_unit.sv]
// Top level of the string literal unescaper
// Takes one source byte per cycle while the queue has room and decodes escapes in
// a single pass between the input register and a four-entry result queue; the
// first result of an accepted byte goes from the input register into the queue
// before it shows on the output port. A byte that follows an unknown escape gives
// two results (the backslash with a warning, then the byte itself), which leave
// through the output port one at a time, so the sustained input rate is one byte
// per cycle as long as results average no more than one per cycle and the sink
// takes them; the queue refuses new bytes once it holds more than two results.
// char_mode selects double-quoted strings (NUL terminator appended) or
// apostrophe-quoted character literals; write it only between literals.
`include "string_literal_unescaper_unit_defines.svh"
module string_literal_unescaper_unit
    import slu_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    slu_byte_if.sink      i_in,
    slu_result_if.source  o_out,
    input  logic          i_cfg_we,
    input  logic          i_cfg_wdata
);

    logic  r_char_mode;
    logic  room;
    t_push push;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_char_mode <= 1'b0;
        end else if (i_cfg_we) begin
            r_char_mode <= i_cfg_wdata;
        end
    end

    slu_decoder u_dec (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_char_mode (r_char_mode),
        .i_room      (room),
        .o_push      (push)
    );

    slu_result_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_room  (room),
        .o_out   (o_out)
    );

    `SLU_ASSERT_IMP(a_pair_starts_with_warning, i_clk, i_rst_n, push.count == 2'd2, push.e0.status == ST_UNKNOWN_ESC)
    `SLU_ASSERT_IMP(a_warning_has_follower, i_clk, i_rst_n, push.count != 2'd0 && push.e0.status == ST_UNKNOWN_ESC, push.count == 2'd2)
    `SLU_ASSERT_IMP(a_no_push_without_room, i_clk, i_rst_n, !room, push.count == 2'd0)
    `SLU_ASSERT_NXT(a_push_shows_result, i_clk, i_rst_n, push.count != 2'd0, o_out.valid)

endmodule
